// ===== hw/rtl/iras_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iras_pkg
// Shared types, constants and helpers of the integer to radix text converter.
// ----------------------------------------------------------------------------
package iras_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned DigitW = 6;
  localparam int unsigned CharW  = 7;
  localparam int unsigned StepW  = $clog2(ValueW);
  localparam int unsigned AddrW  = $clog2(ValueW);
  localparam int unsigned CntW   = $clog2(ValueW + 1);
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 6;

  localparam logic [CfgIdxW-1:0] RegRadix = 1'd0;
  localparam logic [CfgIdxW-1:0] RegUpper = 1'd1;

  localparam logic [DigitW-1:0] RadixReset = 6'd10;
  localparam logic [DigitW-1:0] RadixMin   = 6'd2;
  localparam logic [DigitW-1:0] RadixMax   = 6'd36;
  localparam logic [DigitW-1:0] DigitMax   = 6'd35;

  localparam logic [CharW-1:0] CharMinus = 7'h2D;
  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharLowA  = 7'h61;
  localparam logic [CharW-1:0] CharUpA   = 7'h41;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StSign,
    StFetch,
    StEmit
  } state_e;

  typedef struct packed {
    logic start;
    logic step;
    logic emit_sign;
    logic fetch;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic quot_zero;
    logic store_full;
    logic negative;
    logic cnt_one;
    logic out_free;
  } status_t;

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] digit,
                                                  input logic upper);
    logic [DigitW-1:0] d;
    d = (digit > DigitMax) ? DigitMax : digit;
    if (d < 6'd10) begin
      digit_char = CharZero + CharW'(d);
    end else begin
      digit_char = (upper ? CharUpA : CharLowA) + CharW'(d - 6'd10);
    end
  endfunction

endpackage

// ===== hw/rtl/iras_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iras_ctrl
// Sequencer: accept, divide digit by digit, then emit the sign when negative and the digits.
// ----------------------------------------------------------------------------
module iras_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  iras_pkg::status_t status_i,
  output iras_pkg::cmd_t   cmd_o
);
  import iras_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StDiv;
        end
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        if (status_i.last_step && (status_i.quot_zero || status_i.store_full)) begin
          state_d = status_i.negative ? StSign : StFetch;
        end
      end
      StSign: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = StFetch;
        end
      end
      StFetch: begin
        cmd_o.fetch = 1'b1;
        state_d     = StEmit;
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          state_d          = status_i.cnt_one ? StIdle : StFetch;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// ===== hw/rtl/iras_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iras_dp
// Datapath: config registers, bit-serial divider, digit store, output beat.
// ----------------------------------------------------------------------------
module iras_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [iras_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [iras_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic signed [iras_pkg::ValueW-1:0]   value_i,
  output logic [iras_pkg::CharW-1:0]           character_o,
  output logic                                 last_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  input  iras_pkg::cmd_t                       cmd_i,
  output iras_pkg::status_t                    status_o
);
  import iras_pkg::*;

  logic [DigitW-1:0] radix_q;
  logic              upper_q;
  logic [ValueW-1:0] quot_q;
  logic [DigitW-1:0] rem_q;
  logic [StepW-1:0]  step_q;
  logic [CntW-1:0]   cnt_q;
  logic              neg_q;
  logic [DigitW-1:0] rd_q;
  logic [DigitW-1:0] store_q [ValueW];
  logic [CharW-1:0]  char_q;
  logic              last_q;
  logic              out_valid_q;

  logic [DigitW-1:0] base;
  logic [DigitW:0]   rem_shift;
  logic              ge;
  logic [DigitW-1:0] rem_next;
  logic [ValueW-1:0] quot_next;
  logic [ValueW-1:0] magnitude;
  logic              last_step;
  logic [AddrW-1:0]  rd_addr;
  logic [CntW-1:0]   cnt_dec;

  always_comb begin
    if (radix_q < RadixMin) begin
      base = RadixMin;
    end else if (radix_q > RadixMax) begin
      base = RadixMax;
    end else begin
      base = radix_q;
    end
  end

  assign rem_shift = {rem_q, quot_q[ValueW-1]};
  assign ge        = rem_shift >= {1'b0, base};
  assign rem_next  = ge ? DigitW'(rem_shift - {1'b0, base}) : rem_shift[DigitW-1:0];
  assign quot_next = {quot_q[ValueW-2:0], ge};
  assign magnitude = value_i[ValueW-1] ? (~$unsigned(value_i) + 1'b1) : $unsigned(value_i);
  assign last_step = step_q == StepW'(ValueW - 1);
  assign cnt_dec   = cnt_q - 1'b1;
  assign rd_addr   = cnt_dec[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
      upper_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegRadix: radix_q <= cfg_data_i[DigitW-1:0];
        RegUpper: upper_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      rem_q  <= '0;
      step_q <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
    end else if (cmd_i.start) begin
      quot_q <= magnitude;
      rem_q  <= '0;
      step_q <= '0;
      cnt_q  <= '0;
      neg_q  <= value_i[ValueW-1];
    end else if (cmd_i.step) begin
      quot_q <= quot_next;
      step_q <= step_q + 1'b1;
      if (last_step) begin
        rem_q <= '0;
        cnt_q <= cnt_q + 1'b1;
      end else begin
        rem_q <= rem_next;
      end
    end else if (cmd_i.emit_digit) begin
      cnt_q <= cnt_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && last_step) begin
      store_q[cnt_q[AddrW-1:0]] <= rem_next;
    end
    if (cmd_i.fetch) begin
      rd_q <= store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= CharMinus;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= digit_char(rd_q, upper_q);
      last_q <= cnt_q == CntW'(1);
    end
  end

  assign character_o = char_q;
  assign last_o      = last_q;
  assign out_valid_o = out_valid_q;

  assign status_o.last_step  = last_step;
  assign status_o.quot_zero  = quot_next == '0;
  assign status_o.store_full = cnt_q == CntW'(ValueW - 1);
  assign status_o.negative   = neg_q;
  assign status_o.cnt_one    = cnt_q == CntW'(1);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

// ===== hw/rtl/integer_to_radix_ascii_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_unit
// Converts a signed 32-bit value to ASCII text in a base from 2 to 36.
// ----------------------------------------------------------------------------
// One value is taken at a time and leaves as one beat per character, a minus
// sign first when negative, most significant digit next, last set on the
// final digit. The bit-serial divider shifts one dividend bit per cycle and
// yields one digit per pass over all 32 dividend bits, so a value has up to
// 32 digits; the worst case is base 2 with the most negative value. Each
// digit is then read from the digit store and registered on the output.
// The next value is taken as soon as the last character sits in the output
// register. Bases below 2 act as 2, above 36 as 36.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [iras_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [iras_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [iras_pkg::ValueW-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [iras_pkg::CharW-1:0]          character_o,
  output logic                                last_o
);
  import iras_pkg::*;

  cmd_t    cmd;
  status_t status;

  iras_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  iras_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .value_i     (value_i),
    .character_o (character_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
